// ----- design/sra_pkg.sv -----
// ----------------------------------------------------------------------------
// sra_pkg
// Shared types, codes and helpers for the score register ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package sra_pkg;

  // Data path width of one score register
  localparam int unsigned ScoreW       = 32;
  // Divider step counter width
  localparam int unsigned DivCntW      = $clog2(ScoreW);
  // Index fields carry 8 bits, so at most this many entries are reachable
  localparam int unsigned IdxRange     = 256;
  localparam int unsigned NumScoresDef = 256;

  // Instruction codes
  typedef enum logic [3:0] {
    CMD_SET  = 4'd0,
    CMD_ADDI = 4'd1,
    CMD_SUBI = 4'd2,
    CMD_ADD  = 4'd3,
    CMD_SUB  = 4'd4,
    CMD_MUL  = 4'd5,
    CMD_DIV  = 4'd6,
    CMD_MOD  = 4'd7,
    CMD_GET  = 4'd8
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_ILLEGAL = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_DONE
  } state_e;

  // Request payload
  typedef struct packed {
    logic [3:0]               command;
    logic [7:0]               dest_index;
    logic [7:0]               src_index;
    logic signed [ScoreW-1:0] immediate;
  } sra_req_t;

  // Result payload
  typedef struct packed {
    logic signed [ScoreW-1:0] result_value;
    logic [1:0]               status;
  } sra_rsp_t;

  // Divider start request
  typedef struct packed {
    logic              valid;
    logic [ScoreW-1:0] dividend;
    logic [ScoreW-1:0] divisor;
  } div_req_t;

  // Divider completion
  typedef struct packed {
    logic              done;
    logic [ScoreW-1:0] quotient;
    logic [ScoreW-1:0] remainder;
  } div_rsp_t;

  // Absolute value of a two's complement pattern (most negative maps to 2^31)
  function automatic logic [ScoreW-1:0] magnitude(input logic [ScoreW-1:0] v);
    return v[ScoreW-1] ? ({ScoreW{1'b0}} - v) : v;
  endfunction

endpackage

`default_nettype wire

// ----- design/sra_file.sv -----
// ----------------------------------------------------------------------------
// sra_file
// Score register file: synchronous memory with two registered read ports,
// one write port and per-entry valid bits so that unwritten entries read 0.
// ----------------------------------------------------------------------------
`default_nettype none

module sra_file import sra_pkg::*; #(
  parameter  int unsigned Depth = NumScoresDef,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rd_en_i,
  input  wire logic [AddrW-1:0]  rd_addr_a_i,
  input  wire logic [AddrW-1:0]  rd_addr_b_i,
  output logic      [ScoreW-1:0] rd_data_a_o,
  output logic      [ScoreW-1:0] rd_data_b_o,
  input  wire logic              wr_en_i,
  input  wire logic [AddrW-1:0]  wr_addr_i,
  input  wire logic [ScoreW-1:0] wr_data_i
);

  logic [ScoreW-1:0] mem_q [Depth];
  logic [Depth-1:0]  valid_q;
  logic [ScoreW-1:0] rd_a_q, rd_b_q;
  logic              rd_vld_a_q, rd_vld_b_q;

  // Storage array and registered read data
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_a_q <= mem_q[rd_addr_a_i];
      rd_b_q <= mem_q[rd_addr_b_i];
    end
  end

  // Valid bits: cleared at reset, set on first write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_vld_a_q <= 1'b0;
      rd_vld_b_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_a_q <= valid_q[rd_addr_a_i];
        rd_vld_b_q <= valid_q[rd_addr_b_i];
      end
    end
  end

  // Never-written entries read as the reset value
  assign rd_data_a_o = rd_vld_a_q ? rd_a_q : '0;
  assign rd_data_b_o = rd_vld_b_q ? rd_b_q : '0;

endmodule

`default_nettype wire

// ----- design/sra_div.sv -----
// ----------------------------------------------------------------------------
// sra_div
// Iterative unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sra_div import sra_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [ScoreW-1:0]  quo_q, quo_d;
  logic [ScoreW-1:0]  rem_q, rem_d;
  logic [ScoreW-1:0]  dvs_q, dvs_d;
  logic [ScoreW:0]    shifted;
  logic [ScoreW:0]    diff;

  // One restoring step: shift in next dividend bit, trial subtract
  always_comb begin
    shifted = {rem_q, quo_q[ScoreW-1]};
    diff    = shifted - {1'b0, dvs_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (req_i.valid && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!diff[ScoreW]) begin
        rem_d = diff[ScoreW-1:0];
        quo_d = {quo_q[ScoreW-2:0], 1'b1};
      end else begin
        rem_d = shifted[ScoreW-1:0];
        quo_d = {quo_q[ScoreW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(ScoreW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Data path
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

// ----- design/score_register_alu_top.sv -----
// ----------------------------------------------------------------------------
// score_register_alu_top
// Score instruction unit over a file of signed 32-bit score registers.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_i) is taken at a rising edge with start high and busy low.
//   The unit then stays busy until its single result has been shown.
//   The result (rsp_o) is valid for exactly one cycle, flagged by done_o;
//   there is no back-pressure, so the receiver must take it in that cycle.
//   Each request first reads its operands from the registered score file.
//   Set, add, subtract, multiply, get and illegal commands then show their
//   result; divide and modulo run the 32 steps of the bit-serial divider
//   and a sign fix-up first, while divide by zero skips the divider.
//   A new request can be taken from the cycle after done_o on, so the unit
//   takes no new request before it has shown the result of the last one.
//   Reset clears all score registers at once through per-entry valid bits
//   and returns the sequencer to idle; no clearing pass is needed.
//   Indices are reduced modulo NumScores; at most 256 entries are reachable.
// ----------------------------------------------------------------------------
`default_nettype none

module score_register_alu_top import sra_pkg::*; #(
  parameter int unsigned NumScores = NumScoresDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire sra_req_t req_i,
  output logic          done_o,
  output sra_rsp_t      rsp_o
);

  localparam int unsigned Depth = (NumScores < IdxRange) ? NumScores : IdxRange;
  localparam int unsigned AddrW = $clog2(Depth);

  state_e            state_q, state_d;
  status_e           status_q, status_d;
  logic [3:0]        cmd_q;
  logic [AddrW-1:0]  daddr_q;
  logic [ScoreW-1:0] imm_q;
  logic [ScoreW-1:0] res_q, res_d;
  logic [ScoreW-1:0] tv, sv;
  logic [ScoreW-1:0] prod;
  logic              accept;
  logic              wr_en;
  logic              q_neg;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [AddrW-1:0]  idx_map [IdxRange];

  // Index reduction table, built at elaboration
  for (genvar i = 0; i < IdxRange; i++) begin : g_map
    localparam int unsigned MapVal = i % NumScores;
    assign idx_map[i] = MapVal[AddrW-1:0];
  end

  assign accept = start && !busy;

  sra_file #(
    .Depth (Depth)
  ) u_file (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_addr_a_i (idx_map[req_i.dest_index]),
    .rd_addr_b_i (idx_map[req_i.src_index]),
    .rd_data_a_o (tv),
    .rd_data_b_o (sv),
    .wr_en_i     (wr_en),
    .wr_addr_i   (daddr_q),
    .wr_data_i   (res_q)
  );

  sra_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign prod  = ScoreW'(tv * sv);
  assign q_neg = tv[ScoreW-1] ^ sv[ScoreW-1];

  // Sequencer: read, execute, write back
  always_comb begin
    state_d          = state_q;
    status_d         = status_q;
    res_d            = res_q;
    div_req.valid    = 1'b0;
    div_req.dividend = magnitude(tv);
    div_req.divisor  = magnitude(sv);
    wr_en            = 1'b0;
    busy             = 1'b1;
    done_o           = 1'b0;
    case (state_q)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        status_d = ST_OK;
        state_d  = S_DONE;
        case (cmd_q)
          CMD_SET:  res_d = imm_q;
          CMD_ADDI: res_d = tv + imm_q;
          CMD_SUBI: res_d = tv - imm_q;
          CMD_ADD:  res_d = tv + sv;
          CMD_SUB:  res_d = tv - sv;
          CMD_MUL:  res_d = prod;
          CMD_DIV, CMD_MOD: begin
            if (sv == '0) begin
              res_d    = tv;
              status_d = ST_DIVZERO;
            end else begin
              div_req.valid = 1'b1;
              state_d       = S_DIV;
            end
          end
          CMD_GET:  res_d = tv;
          default: begin
            res_d    = '0;
            status_d = ST_ILLEGAL;
          end
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (cmd_q == CMD_DIV) begin
            res_d = q_neg ? ({ScoreW{1'b0}} - div_rsp.quotient) : div_rsp.quotient;
          end else begin
            res_d = tv[ScoreW-1] ? ({ScoreW{1'b0}} - div_rsp.remainder)
                                 : div_rsp.remainder;
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        done_o  = 1'b1;
        wr_en   = (status_q == ST_OK);
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  // Request and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= req_i.command;
      daddr_q <= idx_map[req_i.dest_index];
      imm_q   <= req_i.immediate;
    end
    res_q <= res_d;
  end

  assign rsp_o.result_value = res_q;
  assign rsp_o.status       = status_q;

endmodule

`default_nettype wire

// ----- design/sra_chk.sv -----
// ----------------------------------------------------------------------------
// sra_chk
// Port-level checks for the score register ALU, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sra_chk import sra_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     start,
  input wire logic     busy,
  input wire sra_req_t req_i,
  input wire logic     done_o,
  input wire sra_rsp_t rsp_o
);

  // A result only shows while a request is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy)
    else $error("result strobe without busy");

  // Result strobe is a single-cycle pulse that ends the request
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !busy)
    else $error("busy held after result");

  // A taken request keeps the unit busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("request taken but not busy");

  // Set returns the immediate with OK status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.command == CMD_SET) |-> ##2
      (done_o && rsp_o.status == ST_OK && rsp_o.result_value == $past(req_i.immediate, 2)))
    else $error("set result mismatch");

  // Illegal commands return zero with illegal status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.command > CMD_GET) |-> ##2
      (done_o && rsp_o.status == ST_ILLEGAL && rsp_o.result_value == '0))
    else $error("illegal command result mismatch");

endmodule

bind score_register_alu_top sra_chk u_sra_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

`default_nettype wire
